[src/tmfs_pkg.sv]
// Shared types, widths, register indexes and reset values of the touch median filter and scaler.
package tmfs_pkg;

  // Field widths.
  localparam int RAW_W    = 13;
  localparam int PIX_W    = 12;
  localparam int WORD_W   = 16;
  localparam int PROD_W   = RAW_W + PIX_W;
  localparam int CFG_IDX_W = 3;

  // Number of samples that go into one median.
  localparam int SAMPLE_COUNT = 5;
  localparam int SAMPLE_IDX_W = $clog2(SAMPLE_COUNT);
  localparam int RANK_W       = $clog2(SAMPLE_COUNT);

  typedef logic [RAW_W-1:0] raw_t;
  typedef logic [PIX_W-1:0] pix_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEPT_LOW    = 3'd0,
    REG_ACCEPT_HIGH   = 3'd1,
    REG_CAL_MIN_X     = 3'd2,
    REG_CAL_MAX_X     = 3'd3,
    REG_CAL_MIN_Y     = 3'd4,
    REG_CAL_MAX_Y     = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_reg_e;

  // Register reset values.
  localparam raw_t ACCEPT_LOW_RST    = 13'd300;
  localparam raw_t ACCEPT_HIGH_RST   = 13'd4000;
  localparam raw_t CAL_MIN_RST       = 13'd300;
  localparam raw_t CAL_MAX_RST       = 13'd4000;
  localparam pix_t SCREEN_WIDTH_RST  = 12'd320;
  localparam pix_t SCREEN_HEIGHT_RST = 12'd240;

  // Status that one axis lane reports to the merging stage.
  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

[src/tmfs_axis_lane.sv]
// One axis lane: median of five, clamp to the calibration range, scale by multiply and divide.
module tmfs_axis_lane import tmfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       ack_i,
  input  raw_t       samples_i [SAMPLE_COUNT],
  input  raw_t       cal_min_i,
  input  raw_t       cal_max_i,
  input  pix_t       size_i,
  output lane_stat_t stat_o,
  output pix_t       result_o
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_MED,
    L_MULT,
    L_DIV,
    L_DONE
  } lane_state_e;

  localparam int STEP_W = $clog2(PROD_W);
  localparam logic [RANK_W-1:0] MED_RANK = RANK_W'(SAMPLE_COUNT / 2);

  // Median by rank: ties are broken by position, so exactly one sample has the middle rank.
  function automatic raw_t median5(input raw_t v [SAMPLE_COUNT]);
    raw_t              med;
    logic [RANK_W-1:0] rank;
    med = v[0];
    for (int i = 0; i < SAMPLE_COUNT; i++) begin
      rank = '0;
      for (int j = 0; j < SAMPLE_COUNT; j++) begin
        if (j != i) begin
          if ((v[j] < v[i]) || ((v[j] == v[i]) && (j < i))) begin
            rank = rank + RANK_W'(1);
          end
        end
      end
      if (rank == MED_RANK) begin
        med = v[i];
      end
    end
    return med;
  endfunction

  lane_state_e         state_q;
  logic [STEP_W-1:0]   step_q;
  raw_t                med_q;
  logic [PROD_W-1:0]   num_q;
  raw_t                den_q;
  raw_t                rem_q;

  raw_t                median_c;
  raw_t                clamped_c;
  raw_t                diff_c;
  logic [PROD_W-1:0]   prod_c;
  logic                degenerate_c;
  logic [RAW_W:0]      shifted_c;
  logic                ge_c;
  logic [RAW_W:0]      sub_c;

  // Median selection over the five stored samples.
  assign median_c = median5(samples_i);

  // Clamp and scale product; a calibration range whose maximum is not above its minimum gives zero.
  always_comb begin
    degenerate_c = (cal_max_i <= cal_min_i);
    clamped_c    = med_q;
    if (med_q < cal_min_i) begin
      clamped_c = cal_min_i;
    end else if (med_q > cal_max_i) begin
      clamped_c = cal_max_i;
    end
    diff_c = clamped_c - cal_min_i;
    prod_c = {{PIX_W{1'b0}}, diff_c} * {{RAW_W{1'b0}}, size_i};
  end

  // One restoring division step: the quotient bits shift into the numerator register.
  always_comb begin
    shifted_c = {rem_q, num_q[PROD_W-1]};
    ge_c      = (shifted_c >= {1'b0, den_q});
    sub_c     = shifted_c - {1'b0, den_q};
  end

  // Lane sequencer with its datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            state_q <= L_MED;
          end
        end
        L_MED: begin
          med_q   <= median_c;
          state_q <= L_MULT;
        end
        L_MULT: begin
          rem_q  <= '0;
          step_q <= STEP_W'(PROD_W - 1);
          if (degenerate_c) begin
            num_q <= '0;
            den_q <= raw_t'(1);
          end else begin
            num_q <= prod_c;
            den_q <= cal_max_i - cal_min_i;
          end
          state_q <= L_DIV;
        end
        L_DIV: begin
          num_q <= {num_q[PROD_W-2:0], ge_c};
          rem_q <= ge_c ? sub_c[RAW_W-1:0] : shifted_c[RAW_W-1:0];
          if (step_q == '0) begin
            state_q <= L_DONE;
          end else begin
            step_q <= step_q - STEP_W'(1);
          end
        end
        L_DONE: begin
          if (ack_i) begin
            state_q <= L_IDLE;
          end
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q != L_IDLE);
  assign stat_o.done = (state_q == L_DONE);
  assign result_o    = num_q[PIX_W-1:0];

endmodule

[src/touch_median_filter_scaler.sv]
// Top level of the touch median filter and scaler: sample collection, axis lanes and result merge.
// Result timing: a pair that completes a read successfully gives its result once both axis lanes
// have passed their median, multiply, divide and done states; a pair that ends a read in failure
// gives its result in the cycle after its transfer. A successful read holds the input off until
// the 25-step divider in each lane is through; other pairs go back to back while the output is free.
// Reset: configuration returns to its defaults, counters clear and the block waits for a start.
module touch_median_filter_scaler import tmfs_pkg::*; #(
  parameter int EXTRA_TRIES = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RAW_W-1:0]     cfg_wdata_i,
  // Sample pairs in.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 start_read_i,
  input  logic [WORD_W-1:0]    x_word_i,
  input  logic [WORD_W-1:0]    y_word_i,
  // Results out.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 read_ok_o,
  output pix_t                 screen_x_o,
  output pix_t                 screen_y_o
);

  localparam int ATTEMPT_LIMIT = SAMPLE_COUNT + EXTRA_TRIES;
  localparam int ATT_W         = $clog2(ATTEMPT_LIMIT);
  localparam int ATT_CNT_W     = $clog2(ATTEMPT_LIMIT + 1);
  localparam int VC_W          = $clog2(SAMPLE_COUNT + 1);

  // Configuration registers.
  raw_t accept_low_q, accept_high_q;
  raw_t cal_min_x_q, cal_max_x_q, cal_min_y_q, cal_max_y_q;
  pix_t screen_width_q, screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_low_q    <= ACCEPT_LOW_RST;
      accept_high_q   <= ACCEPT_HIGH_RST;
      cal_min_x_q     <= CAL_MIN_RST;
      cal_max_x_q     <= CAL_MAX_RST;
      cal_min_y_q     <= CAL_MIN_RST;
      cal_max_y_q     <= CAL_MAX_RST;
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ACCEPT_LOW:    accept_low_q    <= cfg_wdata_i;
        REG_ACCEPT_HIGH:   accept_high_q   <= cfg_wdata_i;
        REG_CAL_MIN_X:     cal_min_x_q     <= cfg_wdata_i;
        REG_CAL_MAX_X:     cal_max_x_q     <= cfg_wdata_i;
        REG_CAL_MIN_Y:     cal_min_y_q     <= cfg_wdata_i;
        REG_CAL_MAX_Y:     cal_max_y_q     <= cfg_wdata_i;
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i[PIX_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Read state and sample stores.
  raw_t               x_store_q [SAMPLE_COUNT];
  raw_t               y_store_q [SAMPLE_COUNT];
  logic [VC_W-1:0]    valid_count_q, valid_count_d;
  logic [ATT_W-1:0]   attempt_count_q, attempt_count_d;
  logic               read_done_q, read_done_d;

  // Output register.
  logic               out_valid_q;
  logic               read_ok_q;
  pix_t               screen_x_q, screen_y_q;

  lane_stat_t         x_stat, y_stat;
  pix_t               x_result, y_result;

  logic               out_free;
  logic               in_xfer;
  logic               lanes_busy;
  logic               merge;
  raw_t               raw_x, raw_y;
  logic               in_window;
  logic               active;
  logic               store_we;
  logic [VC_W-1:0]    vc_base;
  logic [ATT_CNT_W-1:0] att_next;
  logic               read_success;
  logic               read_fail;

  assign lanes_busy = x_stat.busy | y_stat.busy;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = lanes_busy || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign merge      = x_stat.done && y_stat.done && out_free;

  // Evaluation of one transferred pair.
  always_comb begin
    raw_x      = x_word_i[WORD_W-1:WORD_W-RAW_W];
    raw_y      = y_word_i[WORD_W-1:WORD_W-RAW_W];
    in_window  = (raw_x >= accept_low_q) && (raw_x <= accept_high_q) &&
                 (raw_y >= accept_low_q) && (raw_y <= accept_high_q);
    active     = start_read_i || !read_done_q;
    vc_base    = start_read_i ? '0 : valid_count_q;
    att_next   = (start_read_i ? '0 : ATT_CNT_W'(attempt_count_q)) + ATT_CNT_W'(1);
    store_we   = in_xfer && active && in_window && (vc_base < VC_W'(SAMPLE_COUNT));
    valid_count_d   = vc_base + VC_W'(store_we);
    attempt_count_d = ATT_W'(att_next);
    read_success = in_xfer && active && (valid_count_d >= VC_W'(SAMPLE_COUNT));
    read_fail    = in_xfer && active && !read_success &&
                   (att_next >= ATT_CNT_W'(ATTEMPT_LIMIT));
    read_done_d  = read_success || read_fail || !active;
  end

  // Counters and read status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_count_q   <= '0;
      attempt_count_q <= '0;
      read_done_q     <= 1'b1;
    end else if (in_xfer && active) begin
      valid_count_q   <= valid_count_d;
      attempt_count_q <= attempt_count_d;
      read_done_q     <= read_done_d;
    end
  end

  // Sample stores hold no reset; only entries written in the current read are used.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      x_store_q[vc_base[SAMPLE_IDX_W-1:0]] <= raw_x;
      y_store_q[vc_base[SAMPLE_IDX_W-1:0]] <= raw_y;
    end
  end

  // Axis lanes working side by side.
  tmfs_axis_lane u_lane_x (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (read_success),
    .ack_i     (merge),
    .samples_i (x_store_q),
    .cal_min_i (cal_min_x_q),
    .cal_max_i (cal_max_x_q),
    .size_i    (screen_width_q),
    .stat_o    (x_stat),
    .result_o  (x_result)
  );

  tmfs_axis_lane u_lane_y (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (read_success),
    .ack_i     (merge),
    .samples_i (y_store_q),
    .cal_min_i (cal_min_y_q),
    .cal_max_i (cal_max_y_q),
    .size_i    (screen_height_q),
    .stat_o    (y_stat),
    .result_o  (y_result)
  );

  // Merge stage: the lanes' coordinates or a failure result enter the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (merge || read_fail) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (merge) begin
      read_ok_q  <= 1'b1;
      screen_x_q <= x_result;
      screen_y_q <= y_result;
    end else if (read_fail) begin
      read_ok_q  <= 1'b0;
      screen_x_q <= '0;
      screen_y_q <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_ok_o   = read_ok_q;
  assign screen_x_o  = screen_x_q;
  assign screen_y_o  = screen_y_q;

  // The two lanes run in lockstep and finish together.
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_stat.done == y_stat.done)
    else $error("axis lanes out of step");

  // No pair is taken while the lanes are working.
  a_no_xfer_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> !lanes_busy)
    else $error("pair transferred while lanes busy");

  // A failure result carries zero coordinates.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !read_ok_o) |-> (screen_x_o == '0 && screen_y_o == '0))
    else $error("failure result with non-zero coordinates");

  // A completed read always starts the lanes.
  a_success_starts_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_success |=> (x_stat.busy && y_stat.busy && read_done_q))
    else $error("completed read did not start the lanes");

endmodule
